[rtl/core/ikdm_pkg.sv]
// Package: shared types and constants of the interleaved k-way docid merge core.
`default_nettype none
package ikdm_pkg;
  localparam int unsigned KIND_W = 1;
  localparam logic KIND_HEAD = 1'b0;
  localparam logic KIND_SKIP = 1'b1;
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] ADDR_LIST_COUNT = 3'd0;
  localparam logic [3:0] LIST_COUNT_RST = 4'd2;
endpackage
`default_nettype wire

[rtl/core/ikdm_if.sv]
// Interface: valid/ready channel carrying one item of a given payload width.
`default_nettype none
interface ikdm_if #(parameter int unsigned W = 8) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/ikdm_front.sv]
// Front: accepts input beats and stores them in a short queue for the back end.
`default_nettype none
module ikdm_front #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              q_valid,
  input  wire logic         q_pop,
  output logic [W-1:0]      q_data
);
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

[rtl/core/ikdm_back.sv]
// Back: updates heads, scans for the least head, and emits merge or skip results.
`default_nettype none
module ikdm_back #(
  parameter int unsigned MAX_LISTS = 8,
  parameter int unsigned ID_WIDTH  = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [3:0]          list_count,
  input  wire logic                q_valid,
  output logic                     q_pop,
  input  wire logic                kind,
  input  wire logic [2:0]          list_index,
  input  wire logic [ID_WIDTH-1:0] local_docid,
  input  wire logic                list_ended,
  input  wire logic [ID_WIDTH-1:0] target_docid,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              merged_docid,
  output logic [2:0]               current_list,
  output logic                     all_ended,
  output logic [2:0]               skip_list,
  output logic [31:0]              skip_local_target,
  output logic                     last
);
  import ikdm_pkg::*;
  localparam int unsigned LW = $clog2(MAX_LISTS);
  localparam int unsigned KW = $clog2(MAX_LISTS + 1);
  localparam int unsigned DW = ID_WIDTH + KW;
  localparam int unsigned BW = $clog2(ID_WIDTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]          st_r;
  logic [ID_WIDTH-1:0] head_r [MAX_LISTS];
  logic [MAX_LISTS-1:0] live_r;
  logic [KW-1:0]       k_r;
  logic                kind_r;
  logic [LW-1:0]       i_r, best_r;
  logic                found_r;
  logic [ID_WIDTH-1:0] bhead_r, merged_r;
  logic [ID_WIDTH-1:0] g1_r, q_r;
  logic [DW-1:0]       rem_r;
  logic [BW-1:0]       bit_r;
  logic                ov_r;
  logic [31:0]         o_merged_r, o_target_r;
  logic [2:0]          o_cur_r, o_skip_r;
  logic                o_end_r, o_last_r;

  logic [KW-1:0]       keff;
  logic [ID_WIDTH-1:0] hi;
  logic [DW-1:0]       rsh;
  logic [MAX_LISTS-1:0] above;
  logic                more;
  logic [MAX_LISTS-1:0] kmask;
  logic                none_live;
  logic                emit;

  // Saturate K into 2..MAX_LISTS
  always_comb begin
    if ({28'd0, list_count} < 32'd2) keff = KW'(2);
    else if ({28'd0, list_count} > MAX_LISTS) keff = KW'(MAX_LISTS);
    else keff = KW'(list_count);
  end

  assign hi  = head_r[i_r];
  assign rsh = {rem_r[DW-2:0], g1_r[ID_WIDTH-1]};
  // Any live list above the current one below K
  always_comb begin
    for (int j = 0; j < MAX_LISTS; j++)
      above[j] = live_r[j] && (j > i_r) && (j < k_r);
  end
  assign more = |above;

  // Lists below K and whether none of them is live
  assign kmask     = {MAX_LISTS{1'b1}} >> (MAX_LISTS - 32'(k_r));
  assign none_live = ~|(live_r & kmask);

  // A result beat is loaded when the output slot is free or being taken
  assign emit = (!ov_r || out_ready) &&
                ((st_r == S_OUT) || (st_r == S_EMIT && (none_live || live_r[i_r])));

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign merged_docid = o_merged_r;
  assign current_list = o_cur_r;
  assign all_ended = o_end_r;
  assign skip_list = o_skip_r;
  assign skip_local_target = o_target_r;
  assign last = o_last_r;

  // Head storage, written only on a live head update
  always_ff @(posedge clk) begin
    if (q_pop && kind == KIND_HEAD && {29'd0, list_index} < {{(32-KW){1'b0}}, keff}
        && !list_ended)
      head_r[LW'(list_index)] <= local_docid;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; live_r <= '0; ov_r <= 1'b0;
    end else begin
      // Hold a result until taken; load the next one when the slot frees
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_valid) begin
          k_r <= keff; kind_r <= kind;
          g1_r <= target_docid - ID_WIDTH'(1);
          if (kind == KIND_HEAD && {29'd0, list_index} < {{(32-KW){1'b0}}, keff})
            live_r[LW'(list_index)] <= !list_ended;
          i_r <= '0; found_r <= 1'b0; best_r <= '0;
          st_r <= S_SCAN;
        end
        S_SCAN: begin
          if (live_r[i_r] && (!found_r || hi < bhead_r)) begin
            best_r <= i_r; bhead_r <= hi; found_r <= 1'b1;
          end
          if ({{(32-LW){1'b0}}, i_r} == 32'(k_r) - 1) st_r <= S_MUL;
          else i_r <= i_r + LW'(1);
        end
        S_MUL: begin
          merged_r <= ID_WIDTH'((bhead_r - ID_WIDTH'(1)) * k_r) + ID_WIDTH'(best_r)
                      + ID_WIDTH'(1);
          rem_r <= '0; bit_r <= '0; i_r <= '0;
          st_r <= (kind_r == KIND_SKIP) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          // One quotient bit per cycle
          if (rsh >= DW'(k_r)) begin
            rem_r <= rsh - DW'(k_r); q_r <= {q_r[ID_WIDTH-2:0], 1'b1};
          end else begin
            rem_r <= rsh; q_r <= {q_r[ID_WIDTH-2:0], 1'b0};
          end
          g1_r <= {g1_r[ID_WIDTH-2:0], 1'b0};
          if (32'(bit_r) == ID_WIDTH - 1) begin
            st_r <= S_EMIT;
          end
          bit_r <= bit_r + BW'(1);
        end
        S_EMIT: if (!ov_r || out_ready) begin
          if (none_live) begin
            o_merged_r <= 32'(0); o_cur_r <= 3'd0; o_end_r <= 1'b1;
            o_skip_r <= 3'd0; o_target_r <= 32'd0; o_last_r <= 1'b1;
            st_r <= S_IDLE;
          end else if (live_r[i_r]) begin
            o_merged_r <= 32'(merged_r); o_cur_r <= 3'(best_r); o_end_r <= 1'b0;
            o_skip_r <= 3'(i_r);
            o_target_r <= 32'(q_r + ID_WIDTH'(1)
                              + ID_WIDTH'(DW'(rem_r) > DW'(i_r)));
            o_last_r <= !more;
            if (!more) st_r <= S_IDLE;
            else i_r <= i_r + LW'(1);
          end else begin
            i_r <= i_r + LW'(1);
          end
        end
        S_OUT: if (!ov_r || out_ready) begin
          o_merged_r <= found_r ? 32'(merged_r) : 32'd0;
          o_cur_r <= found_r ? 3'(best_r) : 3'd0;
          o_end_r <= !found_r; o_skip_r <= 3'd0; o_target_r <= 32'd0; o_last_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/interleaved_kway_docid_merge_core.sv]
// Top level: K-way interleaved docid merge with APB configuration.
// Head beat: from accept to result it passes the queue, a scan over K lists and a multiply.
// Skip beat: the multiply is followed by a bit-serial divide by K, then one result per
// live list up to the last live one. One item is in the back end at a time.
// Reset (synchronous, rst_n low): no list live, list_count 2, queue and output empty.
`default_nettype none
module interleaved_kway_docid_merge_core #(
  parameter int unsigned MAX_LISTS = 8,
  parameter int unsigned ID_WIDTH  = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ikdm_if.sink      in_ch,
  ikdm_if.source    out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [ikdm_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import ikdm_pkg::*;
  localparam int unsigned IW = 2 + 3 + 2*ID_WIDTH;
  logic [3:0]    lc_r;
  logic          q_valid, q_pop;
  logic [IW-1:0] q_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_LIST_COUNT) ? {28'd0, lc_r} : 32'd0;

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) lc_r <= LIST_COUNT_RST;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_LIST_COUNT)
      lc_r <= cfg_pwdata[3:0];
  end

  ikdm_front #(.W(IW)) u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(IW'(in_ch.data)), .q_valid, .q_pop, .q_data
  );

  // Payload: kind, list_index, local, ended, target (MSB first)
  ikdm_back #(.MAX_LISTS(MAX_LISTS), .ID_WIDTH(ID_WIDTH)) u_back (
    .clk, .rst_n, .list_count(lc_r), .q_valid, .q_pop,
    .kind(q_data[IW-1]), .list_index(q_data[IW-2 -: 3]),
    .local_docid(q_data[2*ID_WIDTH:ID_WIDTH+1]), .list_ended(q_data[ID_WIDTH]),
    .target_docid(q_data[ID_WIDTH-1:0]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .merged_docid(out_ch.data[71:40]), .current_list(out_ch.data[39:37]),
    .all_ended(out_ch.data[36]), .skip_list(out_ch.data[35:33]),
    .skip_local_target(out_ch.data[32:1]), .last(out_ch.data[0])
  );
endmodule
`default_nettype wire

[rtl/core/ikdm_checker.sv]
// Checker: port-level assertions on the merge core, bound to the top level.
`default_nettype none
module ikdm_props (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [71:0] out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data[36] |-> out_data[0] && out_data[71:40] == 32'd0)
    else $error("ended result");
  a_cur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data[36] |-> out_data[39:37] == 3'd0) else $error("ended list");
endmodule
bind interleaved_kway_docid_merge_core ikdm_props u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data[71:0])
);
`default_nettype wire
